// File: hdl/bbt_pkg.sv
// Package for the byte block transposition block.
// Holds sizes, register addresses, control/status structs and the length clamp.
// No dependencies.
package bbt_pkg;

	localparam int MAX_BLOCK = 16;
	localparam int IDX_W     = $clog2(MAX_BLOCK);
	localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
	localparam int KEY_W     = 4;
	localparam int KEY_N     = 16;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 5;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 5;

	// register index, taken from paddr[4:3]
	typedef enum logic [1:0] {
		REG_MODE     = 2'd0,
		REG_LENGTH   = 2'd1,
		REG_KEY_MAP  = 2'd2,
		REG_RESERVED = 2'd3
	} bbt_reg_t;

	localparam logic [KEY_N*KEY_W-1:0] KEY_RESET = 64'hFEDC_BA98_7654_3210;
	localparam logic [LEN_W-1:0]       LEN_RESET = 5'd1;

	// controller to datapath
	typedef struct packed {
		logic wr;     // store the accepted byte
		logic start;  // latch an emission and empty the block
		logic load;   // load the next output byte
	} bbt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic trigger;   // the byte being accepted closes the block
		logic last;      // current output index is the last of the emission
		logic out_free;  // output register can take a byte this cycle
	} bbt_stat_t;

	// clamp the programmed length to 1..MAX_BLOCK
	function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [CNT_W-1:0] res;
		if (len == '0) begin
			res = CNT_W'(1);
		end else if (32'(len) > MAX_BLOCK) begin
			res = CNT_W'(MAX_BLOCK);
		end else begin
			res = CNT_W'(len);
		end
		return res;
	endfunction

endpackage

// File: hdl/bbt_ctrl.sv
// Controller for the byte block transposition block: collect/emit sequencer.
// Depends on bbt_pkg.
module bbt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bbt_pkg::bbt_stat_t stat,
	output bbt_pkg::bbt_cmd_t  cmd
);

	typedef enum logic {
		ST_COLLECT,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready  = (state_q == ST_COLLECT);
		cmd.wr    = in_ready && in_valid;
		cmd.start = cmd.wr && stat.trigger;
		cmd.load  = (state_q == ST_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (cmd.start) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.load && stat.last) begin
						state_q <= ST_COLLECT;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// never store a byte while the block is being emitted
	a_no_wr_during_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> !cmd.load)
		else $error("byte stored during emission");
`endif

endmodule

// File: hdl/bbt_dpath.sv
// Datapath for the byte block transposition block: block store, fill count,
// key lookup and output register. Depends on bbt_pkg.
module bbt_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bbt_pkg::bbt_cmd_t                      cmd,
	output bbt_pkg::bbt_stat_t                     stat,
	input  logic [bbt_pkg::BYTE_W-1:0]             in_data,
	input  logic                                   in_eos,
	input  logic                                   mode,
	input  logic [bbt_pkg::LEN_W-1:0]              block_length,
	input  logic [bbt_pkg::KEY_N*bbt_pkg::KEY_W-1:0] key_map,
	input  logic                                   out_ready,
	output logic                                   out_valid,
	output logic [bbt_pkg::BYTE_W-1:0]             out_byte,
	output logic                                   out_last,
	output logic                                   out_done
);

	logic [bbt_pkg::BYTE_W-1:0] store_q [bbt_pkg::MAX_BLOCK];
	logic [bbt_pkg::CNT_W-1:0]  fill_q;
	logic [bbt_pkg::CNT_W-1:0]  count_q;
	logic [bbt_pkg::IDX_W-1:0]  idx_q;
	logic                       perm_q;
	logic                       eos_q;
	logic                       valid_q;
	logic [bbt_pkg::BYTE_W-1:0] byte_q;
	logic                       last_q;
	logic                       done_q;

	logic [bbt_pkg::CNT_W-1:0]  len;
	logic                       has_room;
	logic [bbt_pkg::CNT_W-1:0]  new_fill;
	logic                       full;
	logic [bbt_pkg::KEY_W-1:0]  key_k;
	logic [bbt_pkg::IDX_W-1:0]  enc_sel;
	logic                       enc_hit;
	logic [bbt_pkg::IDX_W-1:0]  src;
	logic                       hit;
	logic [bbt_pkg::BYTE_W-1:0] emit_byte;

	always_comb begin
		len      = bbt_pkg::eff_len(block_length);
		has_room = (32'(fill_q) < bbt_pkg::MAX_BLOCK);
		new_fill = has_room ? fill_q + bbt_pkg::CNT_W'(1) : fill_q;
		full     = (new_fill >= len);

		stat.trigger  = full || in_eos;
		stat.last     = (idx_q == bbt_pkg::IDX_W'(count_q - bbt_pkg::CNT_W'(1)));
		stat.out_free = !valid_q || out_ready;
	end

	// pick the source entry for output index idx_q
	always_comb begin
		enc_sel = '0;
		enc_hit = 1'b0;
		// encode: the highest input index whose entry names this position
		for (int i = 0; i < bbt_pkg::MAX_BLOCK; i++) begin
			if ((bbt_pkg::CNT_W'(i) < count_q) &&
			    (key_map[i*bbt_pkg::KEY_W +: bbt_pkg::KEY_W] ==
			     bbt_pkg::KEY_W'(idx_q))) begin
				enc_sel = bbt_pkg::IDX_W'(i);
				enc_hit = 1'b1;
			end
		end
		key_k = key_map[32'(idx_q) * bbt_pkg::KEY_W +: bbt_pkg::KEY_W];

		priority if (!perm_q) begin
			src = idx_q;
			hit = 1'b1;
		end else if (mode) begin
			src = bbt_pkg::IDX_W'(key_k);
			hit = (32'(key_k) < 32'(count_q));
		end else begin
			src = enc_sel;
			hit = enc_hit;
		end
		emit_byte = hit ? store_q[src] : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && has_room) begin
			store_q[fill_q[bbt_pkg::IDX_W-1:0]] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= bbt_pkg::CNT_W'(1);
			idx_q   <= '0;
			perm_q  <= 1'b0;
			eos_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				fill_q  <= '0;
				count_q <= full ? len : new_fill;
				perm_q  <= full;
				eos_q   <= in_eos;
				idx_q   <= '0;
			end else if (cmd.wr) begin
				fill_q <= new_fill;
			end
			if (cmd.load) begin
				idx_q   <= idx_q + bbt_pkg::IDX_W'(1);
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= emit_byte;
			last_q <= stat.last;
			done_q <= stat.last && eos_q;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_done  = done_q;

`ifndef ASSERT_OFF
	// an open block never reaches the full store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) < bbt_pkg::MAX_BLOCK)
		else $error("fill count out of range");
	// output index stays inside the latched emission count
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (32'(idx_q) < 32'(count_q)))
		else $error("output index past emission count");
`endif

endmodule

// File: hdl/byte_block_transposition.sv
// Top level of the byte block transposition block: APB register file and
// stream ports. Depends on bbt_pkg, bbt_ctrl and bbt_dpath.
//
// Usage: bytes enter on the s_ stream (s_tlast marks the end of the stream)
// and are collected into a block of block_length bytes (clamped to 1..16).
// When the block fills it is sent on the m_ stream permuted by key_map:
// encode mode scatters input byte i to position key[i], decode mode gathers
// output byte i from input byte key[i]. A partial block closed by s_tlast
// goes out unchanged. m_tlast marks the last beat caused by one input beat,
// m_tuser marks the final beat of the whole stream.
// Timing: one input beat per cycle while a block fills; a closing beat is
// followed by one output beat per cycle while m_tready is high, the first once
// the sequencer has entered its emit state and loaded the output register, and
// s_tready stays low until the emission's last beat is loaded into that register.
// The output register lets the next input beat in while the final output
// beat still waits. A stall on m_tready holds the output register and, during
// an emission, halts it and keeps s_tready low.
// Reset clears the fill count, the sequencer and the output valid, and sets
// mode to encode, block_length to 1 and key_map to the identity. Write the
// registers over APB only while the block is idle.
module byte_block_transposition (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bbt_pkg::ADDR_W-1:0]   paddr,
	input  logic [bbt_pkg::DATA_W-1:0]   pwdata,
	output logic [bbt_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] data_byte
	input  logic                         s_tlast,   // end_of_stream
	// output stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,   // [7:0] out_byte
	output logic                         m_tlast,   // last_of_run
	output logic                         m_tuser    // [0] stream_done
);

	logic                                   mode_q;
	logic [bbt_pkg::LEN_W-1:0]              length_q;
	logic [bbt_pkg::KEY_N*bbt_pkg::KEY_W-1:0] key_map_q;
	bbt_pkg::bbt_reg_t                      reg_sel;
	logic                                   cfg_wr;
	bbt_pkg::bbt_cmd_t                      cmd;
	bbt_pkg::bbt_stat_t                     stat;

	// register index lives in paddr[4:3], eight bytes per register
	assign reg_sel = bbt_pkg::bbt_reg_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			length_q  <= bbt_pkg::LEN_RESET;
			key_map_q <= bbt_pkg::KEY_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				bbt_pkg::REG_MODE:    mode_q    <= pwdata[0];
				bbt_pkg::REG_LENGTH:  length_q  <= pwdata[bbt_pkg::LEN_W-1:0];
				bbt_pkg::REG_KEY_MAP: key_map_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			bbt_pkg::REG_MODE:    prdata = bbt_pkg::DATA_W'(mode_q);
			bbt_pkg::REG_LENGTH:  prdata = bbt_pkg::DATA_W'(length_q);
			bbt_pkg::REG_KEY_MAP: prdata = key_map_q;
			default:              prdata = '0;
		endcase
	end

	bbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bbt_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_data      (s_tdata),
		.in_eos       (s_tlast),
		.mode         (mode_q),
		.block_length (length_q),
		.key_map      (key_map_q),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_byte     (m_tdata),
		.out_last     (m_tlast),
		.out_done     (m_tuser)
	);

`ifndef ASSERT_OFF
	// the final beat of the stream always closes its run
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("stream end without run end");
`endif

endmodule
